>>> src/mrrts_pkg.sv
// ----------------------------------------------------------------------------
// mrrts_pkg
// Shared types and constants for the multicore round-robin task scheduler.
// ----------------------------------------------------------------------------
package mrrts_pkg;

   // default sizes
   localparam int NUM_CORES_DEF    = 4;
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int TASK_ID_BITS_DEF = 8;

   // fixed field widths on the ports
   localparam int CPU_W    = 2;
   localparam int TASK_W   = 8;
   localparam int STATUS_W = 2;

   // func codes
   localparam logic FUNC_CREATE = 1'b0;
   localparam logic FUNC_SCHED  = 1'b1;

   // old_status codes; anything else drops the old task
   localparam logic [STATUS_W-1:0] STATUS_RUNNING = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXITED  = 2'd1;

   typedef struct packed {
      logic                func;
      logic [CPU_W-1:0]    cpu_id;
      logic [TASK_W-1:0]   task_id;
      logic [STATUS_W-1:0] old_status;
   } req_type;

   typedef struct packed {
      logic [CPU_W-1:0]  target_cpu;
      logic              switch_valid;
      logic [TASK_W-1:0] next_task;
      logic              reclaim_valid;
      logic [TASK_W-1:0] reclaim_task;
      logic              queue_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_PLACE,
      ST_POP,
      ST_SWAP,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic start_run;
      logic reclaim;
      logic scan_init;
      logic scan_step;
      logic place;
      logic pop;
      logic swap;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_range;
      logic is_create;
      logic run_valid;
      logic cnt_zero;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

>>> src/mrrts_ram.sv
// ----------------------------------------------------------------------------
// mrrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/mrrts_ctrl.sv
// ----------------------------------------------------------------------------
// mrrts_ctrl
// Sequencer for the scheduler: decides the path of each item and steps the
// datapath through load scan, queue access and result hand-off.
// ----------------------------------------------------------------------------
module mrrts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mrrts_pkg::sts_type sts,
   output mrrts_pkg::cmd_type cmd
);

   import mrrts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.in_range) begin
               state_in = ST_FINISH;
            end else if (sts.is_create) begin
               state_in = sts.run_valid ? ST_SCAN : ST_FINISH;
            end else if (!sts.run_valid || sts.cnt_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_PLACE;
         end
         ST_PLACE:  state_in = ST_FINISH;
         ST_POP:    state_in = ST_SWAP;
         ST_SWAP:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECIDE: begin
            if (sts.in_range) begin
               if (sts.is_create) begin
                  cmd.start_run = !sts.run_valid;
                  cmd.scan_init = sts.run_valid;
               end else begin
                  cmd.reclaim = sts.run_valid;
               end
            end
         end
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_PLACE:  cmd.place     = 1'b1;
         ST_POP:    cmd.pop       = 1'b1;
         ST_SWAP:   cmd.swap      = 1'b1;
         ST_FINISH: cmd.out_load  = sts.out_free;
         default: ;
      endcase
   end

endmodule

>>> src/mrrts_dp.sv
// ----------------------------------------------------------------------------
// mrrts_dp
// Scheduler datapath: per-core running/exit slots, queue pointers and counts,
// shared ready-queue RAM, least-loaded scan registers and result register.
// ----------------------------------------------------------------------------
module mrrts_dp #(
   parameter int NUM_CORES    = mrrts_pkg::NUM_CORES_DEF,
   parameter int QUEUE_DEPTH  = mrrts_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = mrrts_pkg::TASK_ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mrrts_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mrrts_pkg::rsp_type rsp_data,
   input  mrrts_pkg::cmd_type cmd,
   output mrrts_pkg::sts_type sts
);

   import mrrts_pkg::*;

   localparam int CORE_BITS = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_CORES * QUEUE_DEPTH;
   localparam int ADDR_BITS = $clog2(RAM_DEPTH);

   localparam logic [ADDR_BITS-1:0] ROW_SIZE = ADDR_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CORE_BITS-1:0] CORE_LAST = CORE_BITS'(NUM_CORES - 1);

   typedef logic [TASK_ID_BITS-1:0] tid_type;

   function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [CORE_BITS-1:0] c,
                                                      input logic [PTR_BITS-1:0]  p);
      slot_addr = ADDR_BITS'(c) * ROW_SIZE + ADDR_BITS'(p);
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // item and per-core state
   req_type               req_ff;
   logic [CORE_BITS-1:0]  cur_ff, cur_in;
   logic [CORE_BITS-1:0]  best_ff, best_in;
   logic [CNT_BITS-1:0]   best_cnt_ff, best_cnt_in;
   tid_type               run_task_ff [NUM_CORES];
   tid_type               run_task_in [NUM_CORES];
   logic [NUM_CORES-1:0]  run_valid_ff, run_valid_in;
   logic [NUM_CORES-1:0]  exit_pend_ff, exit_pend_in;
   tid_type               exit_task_ff [NUM_CORES];
   tid_type               exit_task_in [NUM_CORES];
   logic [PTR_BITS-1:0]   head_ff [NUM_CORES];
   logic [PTR_BITS-1:0]   head_in [NUM_CORES];
   logic [PTR_BITS-1:0]   tail_ff [NUM_CORES];
   logic [PTR_BITS-1:0]   tail_in [NUM_CORES];
   logic [CNT_BITS-1:0]   cnt_ff [NUM_CORES];
   logic [CNT_BITS-1:0]   cnt_in [NUM_CORES];
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // RAM port
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   tid_type               ram_wdata;
   tid_type               ram_rdata;

   tid_type               item_task;
   logic [CNT_BITS-1:0]   cur_cnt;
   logic                  less;
   logic [CORE_BITS-1:0]  scan_pick;

   assign item_task = TASK_ID_BITS'(req_ff.task_id);
   assign cur_cnt   = cnt_ff[cur_ff];
   assign less      = cur_cnt < best_cnt_ff;
   assign scan_pick = less ? cur_ff : best_ff;

   assign sts.in_range  = (32'(req_ff.cpu_id) < NUM_CORES);
   assign sts.is_create = (req_ff.func == FUNC_CREATE);
   assign sts.run_valid = run_valid_ff[cur_ff];
   assign sts.cnt_zero  = (cur_cnt == '0);
   assign sts.scan_last = (cur_ff == CORE_LAST);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_cnt_in  = best_cnt_ff;
      run_task_in  = run_task_ff;
      run_valid_in = run_valid_ff;
      exit_pend_in = exit_pend_ff;
      exit_task_in = exit_task_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot_addr(cur_ff, tail_ff[cur_ff]);
      ram_wdata    = item_task;

      if (cmd.load) begin
         cur_in            = CORE_BITS'(req_data.cpu_id);
         res_in            = '0;
         res_in.target_cpu = req_data.cpu_id;
      end

      if (cmd.start_run) begin
         run_task_in[cur_ff]  = item_task;
         run_valid_in[cur_ff] = 1'b1;
         res_in.switch_valid  = 1'b1;
         res_in.next_task     = TASK_W'(item_task);
      end

      // reclaim opens every schedule on a busy core
      if (cmd.reclaim && exit_pend_ff[cur_ff]) begin
         res_in.reclaim_valid = 1'b1;
         res_in.reclaim_task  = TASK_W'(exit_task_ff[cur_ff]);
         exit_pend_in[cur_ff] = 1'b0;
      end

      if (cmd.scan_init) begin
         cur_in      = '0;
         best_in     = '0;
         best_cnt_in = '1;
      end

      // one core per cycle; strict less keeps the lowest index on ties
      if (cmd.scan_step) begin
         best_in     = scan_pick;
         best_cnt_in = less ? cur_cnt : best_cnt_ff;
         cur_in      = sts.scan_last ? scan_pick : cur_ff + 1'b1;
      end

      if (cmd.place) begin
         res_in.target_cpu = CPU_W'(cur_ff);
         if (cur_cnt == CNT_FULL) begin
            res_in.queue_full = 1'b1;
         end else begin
            ram_we          = 1'b1;
            tail_in[cur_ff] = ptr_next(tail_ff[cur_ff]);
            cnt_in[cur_ff]  = cur_cnt + 1'b1;
         end
      end

      if (cmd.pop) begin
         head_in[cur_ff] = ptr_next(head_ff[cur_ff]);
         cnt_in[cur_ff]  = cur_cnt - 1'b1;
      end

      // popped head is in ram_rdata; pop already freed a slot for a requeue
      if (cmd.swap) begin
         if (req_ff.old_status == STATUS_RUNNING) begin
            ram_we          = 1'b1;
            ram_wdata       = run_task_ff[cur_ff];
            tail_in[cur_ff] = ptr_next(tail_ff[cur_ff]);
            cnt_in[cur_ff]  = cur_cnt + 1'b1;
         end else if (req_ff.old_status == STATUS_EXITED) begin
            exit_pend_in[cur_ff] = 1'b1;
            exit_task_in[cur_ff] = run_task_ff[cur_ff];
         end
         run_task_in[cur_ff] = ram_rdata;
         res_in.switch_valid = 1'b1;
         res_in.next_task    = TASK_W'(ram_rdata);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= '0;
         exit_pend_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CORES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         run_valid_ff <= run_valid_in;
         exit_pend_ff <= exit_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      best_cnt_ff  <= best_cnt_in;
      run_task_ff  <= run_task_in;
      exit_task_ff <= exit_task_in;
      res_ff       <= res_in;
   end

   mrrts_ram #(
      .WIDTH (TASK_ID_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ready_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.pop),
      .raddr (slot_addr(cur_ff, head_ff[cur_ff])),
      .rdata (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/multicore_round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// multicore_round_robin_task_scheduler
// Task scheduler with one FIFO ready queue, one running slot and one exit
// slot per core. A create beat starts the task on an idle calling core, or
// appends it to the least-loaded queue (lowest index on ties; queue_full and
// a drop when that queue is full). A schedule beat on a busy core hands back
// a pending exited task, then, if its queue holds work, pops the head to run
// and requeues, parks or drops the old task by old_status. Every request
// beat yields exactly one response beat. One item is in work at a time;
// a schedule that switches pops the head and then swaps it in, as the
// ready-queue RAM has a registered read, and a placement walks the
// per-core counts one core per cycle. A finished response sits in an
// output register, so the next request is taken while it waits. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module multicore_round_robin_task_scheduler #(
   parameter int NUM_CORES    = mrrts_pkg::NUM_CORES_DEF,
   parameter int QUEUE_DEPTH  = mrrts_pkg::QUEUE_DEPTH_DEF,
   parameter int TASK_ID_BITS = mrrts_pkg::TASK_ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mrrts_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mrrts_pkg::rsp_type rsp_data
);

   import mrrts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mrrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrrts_dp #(
      .NUM_CORES    (NUM_CORES),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("response register overwritten");

   // sequencer issues one step at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

   // busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a dropped placement never switches or reclaims
   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.queue_full) |->
         (!rsp_data.switch_valid && !rsp_data.reclaim_valid))
      else $error("queue_full with switch or reclaim");

endmodule
